@@ design/rasr_pkg.sv @@
// Shared widths, operation codes and port types for the rational add/subtract/reduce core.
`default_nettype none
package rasr_pkg;

  // Width of each input numerator and denominator
  localparam int IN_WIDTH = 16;

  // Products, sums and magnitudes
  localparam int PROD_W = 2 * IN_WIDTH;
  localparam int SUM_W  = 2 * IN_WIDTH + 1;
  localparam int MAG_W  = 2 * IN_WIDTH;

  // Result field widths
  localparam int NUM_OUT_W = 33;
  localparam int DEN_OUT_W = 32;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((4 * IN_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((NUM_OUT_W + DEN_OUT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - NUM_OUT_W - DEN_OUT_W;

  // Divider step counter
  localparam int DIV_CNT_W = $clog2(MAG_W);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_CMP = 2'd2
  } op_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [MAG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quo;
    logic [MAG_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ design/rasr_mul.sv @@
// Shared signed multiplier with registered product.
`default_nettype none
module rasr_mul
  import rasr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [IN_WIDTH-1:0] a,
  input  wire logic signed [IN_WIDTH-1:0] b,
  output logic signed [PROD_W-1:0]      p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule
`default_nettype wire

@@ design/rasr_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module rasr_div
  import rasr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [MAG_W-1:0]     dsr;
  logic [MAG_W-1:0]     quo;
  logic [MAG_W-1:0]     rem;
  logic                 done;

  logic [MAG_W:0]       rem_sh;
  logic [MAG_W:0]       diff;
  logic [MAG_W-1:0]     rem_next;
  logic [MAG_W-1:0]     quo_next;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    rem_sh = {rem, quo[MAG_W-1]};
    diff   = rem_sh - {1'b0, dsr};
    if (!diff[MAG_W]) begin
      rem_next = diff[MAG_W-1:0];
      quo_next = {quo[MAG_W-2:0], 1'b1};
    end else begin
      rem_next = rem_sh[MAG_W-1:0];
      quo_next = {quo[MAG_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(MAG_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule
`default_nettype wire

@@ design/rational_add_sub_reduce_core.sv @@
// Top level: sequencer for fraction add, subtract, equality test and gcd reduction.
//
// Input channel s_axis: one beat carries two fractions and an operation in
// tuser (0 add, 1 subtract, 2 compare). Output channel m_axis: one beat per
// input beat with the reduced numerator and denominator in tdata and the
// equality and zero-denominator flags in tuser.
// A beat is taken only while the sequencer is idle; it is then busy until
// its result has been placed in the output register. One shared multiplier
// forms the three cross products, and one shared 32-step restoring divider
// runs every Euclid remainder step and both final exact divisions. An add or
// subtract runs k Euclid remainder steps (1 <= k <= 44) before the two exact
// divisions; a compare skips the divider, and an item with a zero denominator
// or an unused operation code skips both shared units.
// s_axis_tready rises in the same cycle as m_axis_tvalid.
// Reset (rst, synchronous) clears the sequencer and the output valid flag.
// When the receiver stalls, the finished result holds in the output
// register; the next beat may still be accepted and worked on, and its result
// waits in the sequencer until the output register is free.
`default_nettype none
module rational_add_sub_reduce_core
  import rasr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [15:0] num_a, [31:16] den_a, [47:32] num_b, [63:48] den_b
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  wire logic [1:0]             s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [32:0] result_num, [64:33] result_den, [71:65] zero padding
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // [0] is_equal, [1] zero_den_error
  output logic [1:0]                  m_axis_tuser
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_PREP,
    S_EUC,
    S_EUC_WAIT,
    S_DIVN,
    S_DIVN_WAIT,
    S_DIVD,
    S_DIVD_WAIT,
    S_DONE
  } state_t;

  state_t state;

  // Held request
  op_t                       req_op;
  logic signed [IN_WIDTH-1:0] na;
  logic signed [IN_WIDTH-1:0] da;
  logic signed [IN_WIDTH-1:0] nb;
  logic signed [IN_WIDTH-1:0] db;

  // Cross products and reduction working set
  logic signed [PROD_W-1:0]  p1;
  logic signed [PROD_W-1:0]  p2;
  logic                      num_neg;
  logic                      den_neg;
  logic [MAG_W-1:0]          mag_num;
  logic [MAG_W-1:0]          mag_den;
  logic [MAG_W-1:0]          ea;
  logic [MAG_W-1:0]          eb;
  logic [MAG_W-1:0]          q_num;

  // Finished result, waiting for the output register
  logic [NUM_OUT_W-1:0]      res_num;
  logic [DEN_OUT_W-1:0]      res_den;
  logic                      res_eq;
  logic                      res_err;

  // Output register
  logic                      out_valid;
  logic [NUM_OUT_W-1:0]      o_num;
  logic [DEN_OUT_W-1:0]      o_den;
  logic                      o_eq;
  logic                      o_err;

  // Shared units
  logic signed [IN_WIDTH-1:0] mul_a;
  logic signed [IN_WIDTH-1:0] mul_b;
  logic signed [PROD_W-1:0]   prod;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  // Request fields
  logic signed [IN_WIDTH-1:0] in_na;
  logic signed [IN_WIDTH-1:0] in_da;
  logic signed [IN_WIDTH-1:0] in_nb;
  logic signed [IN_WIDTH-1:0] in_db;
  logic                       in_beat;

  // Raw numerator and magnitudes
  logic signed [SUM_W-1:0]    raw_num;
  logic [MAG_W-1:0]           raw_num_mag;
  logic [MAG_W-1:0]           raw_den_mag;

  assign in_na   = s_axis_tdata[IN_WIDTH-1:0];
  assign in_da   = s_axis_tdata[2*IN_WIDTH-1:IN_WIDTH];
  assign in_nb   = s_axis_tdata[3*IN_WIDTH-1:2*IN_WIDTH];
  assign in_db   = s_axis_tdata[4*IN_WIDTH-1:3*IN_WIDTH];
  assign in_beat = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == S_IDLE);

  // Multiplier operands: n_a*d_b, then n_b*d_a, then d_a*d_b
  always_comb begin
    case (state)
      S_MUL1: begin
        mul_a = na;
        mul_b = db;
      end
      S_MUL2: begin
        mul_a = nb;
        mul_b = da;
      end
      default: begin
        mul_a = da;
        mul_b = db;
      end
    endcase
  end

  rasr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Raw numerator from the held products; the product register holds d_a*d_b in S_PREP
  always_comb begin
    if (req_op == OP_SUB) begin
      raw_num = SUM_W'(p1) - SUM_W'(p2);
    end else begin
      raw_num = SUM_W'(p1) + SUM_W'(p2);
    end
    raw_num_mag = raw_num[SUM_W-1] ? MAG_W'(-raw_num) : MAG_W'(raw_num);
    raw_den_mag = prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
  end

  // Divider requests: Euclid remainder, then the two exact divisions by the gcd
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = ea;
    div_req.divisor  = eb;
    case (state)
      S_EUC: begin
        div_req.start = (eb != '0);
      end
      S_DIVN: begin
        div_req.start    = 1'b1;
        div_req.dividend = mag_num;
        div_req.divisor  = ea;
      end
      S_DIVD: begin
        div_req.start    = 1'b1;
        div_req.dividend = mag_den;
        div_req.divisor  = ea;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  rasr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the output beat once taken, unless a new one replaces it
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_beat) begin
            req_op  <= op_t'(s_axis_tuser);
            na      <= in_na;
            da      <= in_da;
            nb      <= in_nb;
            db      <= in_db;
            res_num <= '0;
            res_den <= '0;
            res_eq  <= 1'b0;
            res_err <= (in_da == '0 || in_db == '0);
            if (in_da == '0 || in_db == '0) begin
              state   <= S_DONE;
            end else begin
              case (s_axis_tuser)
                OP_ADD, OP_SUB, OP_CMP: state <= S_MUL1;
                default:                state <= S_DONE;
              endcase
            end
          end
        end

        S_MUL1: begin
          state <= S_MUL2;
        end

        S_MUL2: begin
          p1    <= prod;
          state <= S_MUL3;
        end

        S_MUL3: begin
          p2    <= prod;
          state <= S_PREP;
        end

        S_PREP: begin
          if (req_op == OP_CMP) begin
            res_eq <= (p1 == p2);
            state  <= S_DONE;
          end else begin
            num_neg <= raw_num[SUM_W-1];
            den_neg <= prod[PROD_W-1];
            mag_num <= raw_num_mag;
            mag_den <= raw_den_mag;
            ea      <= raw_num_mag;
            eb      <= raw_den_mag;
            state   <= S_EUC;
          end
        end

        S_EUC: begin
          // Once the remainder reaches zero, ea holds the gcd
          if (eb == '0) begin
            state <= S_DIVN;
          end else begin
            state <= S_EUC_WAIT;
          end
        end

        S_EUC_WAIT: begin
          if (div_rsp.done) begin
            ea    <= eb;
            eb    <= div_rsp.rem;
            state <= S_EUC;
          end
        end

        S_DIVN: begin
          state <= S_DIVN_WAIT;
        end

        S_DIVN_WAIT: begin
          if (div_rsp.done) begin
            q_num <= div_rsp.quo;
            state <= S_DIVD;
          end
        end

        S_DIVD: begin
          state <= S_DIVD_WAIT;
        end

        S_DIVD_WAIT: begin
          if (div_rsp.done) begin
            res_num <= num_neg ? NUM_OUT_W'(-NUM_OUT_W'(q_num)) : NUM_OUT_W'(q_num);
            res_den <= den_neg ? DEN_OUT_W'(-DEN_OUT_W'(div_rsp.quo))
                               : DEN_OUT_W'(div_rsp.quo);
            state   <= S_DONE;
          end
        end

        S_DONE: begin
          // Hold here until the output register is free or being emptied
          if (!out_valid || m_axis_tready) begin
            o_num     <= res_num;
            o_den     <= res_den;
            o_eq      <= res_eq;
            o_err     <= res_err;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, o_den, o_num};
  assign m_axis_tuser  = {o_err, o_eq};

endmodule
`default_nettype wire

@@ dv/tb_rational_add_sub_reduce_core.sv @@
// Self-checking testbench for the rational add/subtract/compare core with gcd reduction.
`timescale 1ns / 100ps
module tb_rational_add_sub_reduce_core;
  import rasr_pkg::*;

  // Operation code that the core treats as a no-op
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam int RANDOM_ITEMS = 800;
  localparam int DIRECTED_ROWS = 25;
  // Worst Euclid chain on these magnitudes is at most 44 steps
  localparam int SETTLE_CYCLES = 2000;
  localparam int CYCLE_LIMIT = 5_000_000;

  // One request beat, with an optional expected result typed in by hand
  typedef struct packed {
    logic [1:0]          op;
    logic [IN_WIDTH-1:0] na;
    logic [IN_WIDTH-1:0] da;
    logic [IN_WIDTH-1:0] nb;
    logic [IN_WIDTH-1:0] db;
    logic                typed;
    logic [NUM_OUT_W-1:0] num;
    logic [DEN_OUT_W-1:0] den;
    logic                eq;
    logic                err;
  } frac_req_t;

  typedef struct packed {
    logic [NUM_OUT_W-1:0] num;
    logic [DEN_OUT_W-1:0] den;
    logic                 eq;
    logic                 err;
  } frac_res_t;

  // Directed rows: zero sums, extremes, zero denominators, the no-op code, compares
  localparam frac_req_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_ADD, 16'd0, 16'd1, 16'd0, 16'd1, 1'b1, 33'd0, 32'd1, 1'b0, 1'b0},
    '{OP_ADD, 16'd1, 16'd2, -16'sd1, 16'd2, 1'b1, 33'd0, 32'd1, 1'b0, 1'b0},
    '{OP_ADD, 16'd1, -16'sd2, 16'd1, 16'd2, 1'b1, 33'd0, -32'sd1, 1'b0, 1'b0},
    '{OP_SUB, 16'd3, 16'd4, 16'd3, 16'd4, 1'b1, 33'd0, 32'd1, 1'b0, 1'b0},
    '{OP_SUB, 16'd5, -16'sd7, 16'd5, -16'sd7, 1'b1, 33'd0, 32'd1, 1'b0, 1'b0},
    '{OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 33'd2, 32'd1, 1'b0, 1'b0},
    '{OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 33'd2, 32'd1, 1'b0, 1'b0},
    '{OP_ADD, 16'h7FFF, 16'd1, 16'h7FFF, 16'd1, 1'b1, 33'd65534, 32'd1, 1'b0, 1'b0},
    '{OP_SUB, 16'h8000, 16'd1, 16'h7FFF, 16'd1, 1'b1, -33'sd65535, 32'd1, 1'b0, 1'b0},
    '{OP_ADD, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, 33'd0, 32'd0, 1'b0, 1'b0},
    '{OP_SUB, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0, 33'd0, 32'd0, 1'b0, 1'b0},
    '{OP_ADD, 16'd1, 16'd3, 16'd1, 16'd6, 1'b0, 33'd0, 32'd0, 1'b0, 1'b0},
    '{OP_SUB, 16'd7, -16'sd12, 16'd5, 16'd18, 1'b0, 33'd0, 32'd0, 1'b0, 1'b0},
    '{OP_ADD, 16'd5, 16'd0, 16'd1, 16'd1, 1'b1, 33'd0, 32'd0, 1'b0, 1'b1},
    '{OP_SUB, 16'd1, 16'd1, 16'd1, 16'd0, 1'b1, 33'd0, 32'd0, 1'b0, 1'b1},
    '{OP_CMP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 33'd0, 32'd0, 1'b0, 1'b1},
    '{OP_NONE, 16'd3, 16'd0, 16'd1, 16'd1, 1'b1, 33'd0, 32'd0, 1'b0, 1'b1},
    '{OP_NONE, 16'd3, 16'd4, 16'd5, 16'd6, 1'b1, 33'd0, 32'd0, 1'b0, 1'b0},
    '{OP_CMP, 16'd1, 16'd2, 16'd2, 16'd4, 1'b1, 33'd0, 32'd0, 1'b1, 1'b0},
    '{OP_CMP, 16'd1, 16'd2, 16'd1, 16'd3, 1'b1, 33'd0, 32'd0, 1'b0, 1'b0},
    '{OP_CMP, -16'sd1, 16'd2, 16'd1, -16'sd2, 1'b1, 33'd0, 32'd0, 1'b1, 1'b0},
    '{OP_CMP, 16'd0, 16'd5, 16'd0, -16'sd7, 1'b1, 33'd0, 32'd0, 1'b1, 1'b0},
    '{OP_CMP, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, 33'd0, 32'd0, 1'b1, 1'b0},
    '{OP_CMP, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b1, 33'd0, 32'd0, 1'b1, 1'b0},
    '{OP_ADD, 16'd0, 16'hFFFF, 16'd0, 16'h8000, 1'b1, 33'd0, 32'd1, 1'b0, 1'b0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;

  frac_req_t requests[$];
  frac_res_t pending_results[$];
  frac_res_t got;
  frac_res_t want;
  frac_req_t cur;
  int        request_total = 0;
  int        accepted = 0;
  int        outstanding = 0;
  int        result_beats = 0;
  int        faults = 0;
  int        cycle_count = 0;
  int        phase;
  int        sender_idle;
  int        sink_idle;
  int        op_count [4] = '{0, 0, 0, 0};
  int        flagged = 0;
  int        equal_hits = 0;

  rational_add_sub_reduce_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cross-multiply, reduce by the gcd of the magnitudes, keep the denominator sign
  function automatic frac_res_t fraction_result(frac_req_t r);
    longint    p_ab;
    longint    p_ba;
    longint    raw_num;
    longint    raw_den;
    longint    a;
    longint    b;
    longint    rem;
    frac_res_t res;
    res = '0;
    if (r.da == '0 || r.db == '0) begin
      res.err = 1'b1;
    end else begin
      p_ab = longint'($signed(r.na)) * longint'($signed(r.db));
      p_ba = longint'($signed(r.nb)) * longint'($signed(r.da));
      if (r.op == OP_ADD || r.op == OP_SUB) begin
        raw_num = (r.op == OP_ADD) ? p_ab + p_ba : p_ab - p_ba;
        raw_den = longint'($signed(r.da)) * longint'($signed(r.db));
        a = (raw_num < 0) ? -raw_num : raw_num;
        b = (raw_den < 0) ? -raw_den : raw_den;
        while (b != 0) begin
          rem = a % b;
          a = b;
          b = rem;
        end
        // exact divisions, so truncation keeps the sign as computed
        raw_num = raw_num / a;
        raw_den = raw_den / a;
        res.num = raw_num[NUM_OUT_W-1:0];
        res.den = raw_den[DEN_OUT_W-1:0];
      end else if (r.op == OP_CMP) begin
        res.eq = (p_ab == p_ba);
      end
    end
    return res;
  endfunction

  task automatic check_field(string label, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      faults++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, exp_val, act_val);
    end
  endtask

  // Both sides of the stream: accept and predict, check results, pace the idling
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        cur = requests[accepted];
        pending_results.push_back(cur.typed ? frac_res_t'({cur.num, cur.den, cur.eq, cur.err})
                                            : fraction_result(cur));
        op_count[cur.op]++;
        accepted++;
        outstanding++;
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.num = m_axis_tdata[NUM_OUT_W-1:0];
        got.den = m_axis_tdata[NUM_OUT_W+DEN_OUT_W-1:NUM_OUT_W];
        got.eq  = m_axis_tuser[0];
        got.err = m_axis_tuser[1];
        if (pending_results.size() == 0) begin
          faults++;
          $display("%0t: result beat with nothing expected, got num %0d den %0d eq %0b err %0b",
                   $time, $signed(got.num), $signed(got.den), got.eq, got.err);
        end else begin
          want = pending_results.pop_front();
          outstanding--;
          result_beats++;
          flagged += want.err;
          equal_hits += want.eq;
          check_field("result_num", longint'($signed(want.num)), longint'($signed(got.num)));
          check_field("result_den", longint'($signed(want.den)), longint'($signed(got.den)));
          check_field("is_equal", longint'(want.eq), longint'(got.eq));
          check_field("zero_den_error", longint'(want.err), longint'(got.err));
        end
      end

      // first third: sender idles lightly, receiver heavily; second third swapped; then none
      phase = (accepted * 3) / request_total;
      sender_idle = (phase == 0) ? 26 : (phase == 1) ? 50 : 0;
      sink_idle = (phase == 0) ? 50 : (phase == 1) ? 26 : 0;

      // hold the beat until it is taken; only then offer the next one
      if (!s_axis_tvalid || s_axis_tready) begin
        if (accepted < request_total && $urandom_range(0, 99) >= sender_idle) begin
          cur = requests[accepted];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {cur.db, cur.nb, cur.da, cur.na};
          s_axis_tuser <= cur.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);
    end
  end

  // Build the stimulus, release reset, then wait for the last result to drain
  initial begin
    frac_req_t row;
    int        pick;
    int        na_s;
    int        da_s;
    int        nb_s;
    int        db_s;
    int        scale;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      requests.push_back(DIRECTED[i]);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      row = '0;
      pick = $urandom_range(0, 19);
      row.op = (pick < 7) ? OP_ADD : (pick < 14) ? OP_SUB : (pick < 19) ? OP_CMP : OP_NONE;
      if ($urandom_range(0, 99) < 35) begin
        // full-width operands: every bit toggles, long Euclid chains
        {row.db, row.nb, row.da, row.na} = {$urandom, $urandom};
      end else begin
        // small operands: frequent common factors, zero sums and equal compares
        na_s = int'($urandom_range(0, 60)) - 30;
        nb_s = int'($urandom_range(0, 60)) - 30;
        da_s = int'($urandom_range(1, 30)) * (($urandom_range(0, 1) == 1) ? -1 : 1);
        db_s = int'($urandom_range(1, 30)) * (($urandom_range(0, 1) == 1) ? -1 : 1);
        if ($urandom_range(0, 2) == 0) begin
          // scaled copy of the first fraction: equal for compare, zero for subtract
          scale = int'($urandom_range(1, 9)) * (($urandom_range(0, 1) == 1) ? -1 : 1);
          nb_s = na_s * scale;
          db_s = da_s * scale;
        end
        row.na = IN_WIDTH'(na_s);
        row.da = IN_WIDTH'(da_s);
        row.nb = IN_WIDTH'(nb_s);
        row.db = IN_WIDTH'(db_s);
      end
      // occasional zero denominator as noise
      if ($urandom_range(0, 24) == 0) row.da = '0;
      if ($urandom_range(0, 24) == 0) row.db = '0;
      requests.push_back(row);
    end
    request_total = requests.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    wait (accepted == request_total && outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d request beats (%0d add, %0d subtract, %0d compare, %0d unused code).",
             accepted, op_count[OP_ADD], op_count[OP_SUB], op_count[OP_CMP], op_count[OP_NONE]);
    $display("Checked %0d result beats, %0d with a zero denominator, %0d equal compares.",
             result_beats, flagged, equal_hits);
    if (faults == 0) begin
      $display("rational_add_sub_reduce_core verification clean");
    end else begin
      $display("rational_add_sub_reduce_core verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d results outstanding", cycle_count, outstanding);
    $display("rational_add_sub_reduce_core verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/rasr_pkg.sv
design/rasr_mul.sv
design/rasr_div.sv
design/rational_add_sub_reduce_core.sv
dv/tb_rational_add_sub_reduce_core.sv
